>>> design/cdtwg_pkg.sv
`default_nettype none
package cdtwg_pkg;

  localparam int ACT_W = 2;
  localparam int SYM_W = 2;
  localparam int SMP_W = 16;
  localparam int CNT_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int PHASE_W = 32;

  // register slots in the sine unit, phase in to sine out
  localparam int SINE_STAGES = 9;

  typedef enum logic [ACT_W-1:0] {
    ACT_PREAMBLE = 2'd0,
    ACT_SYMBOL   = 2'd1,
    ACT_NEXT     = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_PRE  = 3'b010,
    MODE_SYM  = 3'b100
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_CHIRP_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHIRP_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHIRP_DELTA = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_INC    = 2'd3;

  localparam logic [31:0] RST_CHIRP_START = 32'd536870912;
  localparam logic [31:0] RST_CHIRP_END   = 32'd1431655765;
  localparam logic [31:0] RST_CHIRP_DELTA = 32'd3495253;
  localparam logic [31:0] RST_TONE_INC    = 32'd501079518;

  // Q14 polynomial coefficients
  localparam logic [14:0] SIN_A = 15'd25736;
  localparam logic [13:0] SIN_B = 14'd10512;
  localparam logic [10:0] SIN_C = 11'd1160;
  localparam logic [14:0] QUARTER = 15'd16384;

  typedef struct packed {
    logic is_sym;
    logic neg_a;
    logic neg_b;
    logic last;
    logic active;
  } ctrl_t;

endpackage
`default_nettype wire

>>> design/cdtwg_in_if.sv
`default_nettype none
interface cdtwg_in_if;
  import cdtwg_pkg::*;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [SYM_W-1:0] symbol;
  modport source(output valid, output action, output symbol, input ready);
  modport sink(input valid, input action, input symbol, output ready);
endinterface
`default_nettype wire

>>> design/cdtwg_out_if.sv
`default_nettype none
interface cdtwg_out_if;
  import cdtwg_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample;
  logic                    last;
  logic                    active;
  modport source(output valid, output sample, output last, output active, input ready);
  modport sink(input valid, input sample, input last, input active, output ready);
endinterface
`default_nettype wire

>>> design/cdtwg_cfg_if.sv
`default_nettype none
interface cdtwg_cfg_if;
  import cdtwg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> design/cdtwg_sine.sv
`default_nettype none
module cdtwg_sine #(
  parameter int DEPTH = 1024
) (
  input  wire                                    clk,
  input  wire [cdtwg_pkg::SINE_STAGES-1:0]       en,
  input  wire [cdtwg_pkg::PHASE_W-1:0]           phase,
  output logic signed [cdtwg_pkg::SMP_W-1:0]     sine
);
  import cdtwg_pkg::*;

  localparam int KW = $clog2(DEPTH);
  localparam int DW = $clog2(DEPTH + 1);
  // floor(2^48 / DEPTH); quotient estimate is exact or one low
  localparam logic [47:0] RECIP = 48'((64'd1 << 48) / DEPTH);

  // table index k = phase * DEPTH >> 32
  logic [31+DW:0] m1;
  logic [KW-1:0]  k1_r;
  assign m1 = (32 + DW)'(phase) * (32 + DW)'(DEPTH);

  // u = (k << 16) / DEPTH by reciprocal
  logic [47:0]   m2;
  logic [15:0]   q2_r;
  logic [KW-1:0] k2_r;
  assign m2 = 48'(k1_r) * RECIP;

  logic [31:0]   m3;
  logic [31:0]   m3_r;
  logic [15:0]   q3_r;
  logic [KW-1:0] k3_r;
  assign m3 = 32'(q2_r) * 32'(DEPTH);

  logic [31:0] num;
  logic [31:0] rem;
  logic [15:0] u;
  logic [14:0] z;
  logic [14:0] z4_r;
  logic [1:0]  qd4_r;
  assign num = 32'(k3_r) << 16;
  assign rem = num - m3_r;
  assign u   = (rem >= 32'(DEPTH)) ? q3_r + 16'd1 : q3_r;
  assign z   = u[14] ? QUARTER - {1'b0, u[13:0]} : {1'b0, u[13:0]};

  logic [29:0] p5;
  logic [14:0] z2_5_r;
  logic [14:0] z5_r;
  logic [1:0]  qd5_r;
  assign p5 = 30'(z4_r) * 30'(z4_r);

  logic [25:0] p6;
  logic [10:0] t1_6_r;
  logic [14:0] z2_6_r;
  logic [14:0] z6_r;
  logic [1:0]  qd6_r;
  assign p6 = 26'(z2_5_r) * 26'(SIN_C);

  logic [13:0] d7;
  logic [28:0] p7;
  logic [13:0] t7_r;
  logic [14:0] z7_r;
  logic [1:0]  qd7_r;
  assign d7 = SIN_B - 14'(t1_6_r);
  assign p7 = 29'(z2_6_r) * 29'(d7);

  logic [14:0] d8;
  logic [29:0] p8;
  logic [14:0] y8_r;
  logic [1:0]  qd8_r;
  assign d8 = SIN_A - 15'(t7_r);
  assign p8 = 30'(z7_r) * 30'(d8);

  logic [15:0]             h;
  logic signed [SMP_W-1:0] sine_nxt;
  logic signed [SMP_W-1:0] sine_r;
  assign h        = (16'(y8_r) + 16'd1) >> 1;
  assign sine_nxt = qd8_r[1] ? -$signed(h) : $signed(h);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      k1_r <= m1[32 +: KW];
    end
    if (en[1]) begin
      q2_r <= m2[47:32];
      k2_r <= k1_r;
    end
    if (en[2]) begin
      m3_r <= m3;
      q3_r <= q2_r;
      k3_r <= k2_r;
    end
    if (en[3]) begin
      z4_r  <= z;
      qd4_r <= u[15:14];
    end
    if (en[4]) begin
      z2_5_r <= p5[28:14];
      z5_r   <= z4_r;
      qd5_r  <= qd4_r;
    end
    if (en[5]) begin
      t1_6_r <= p6[24:14];
      z2_6_r <= z2_5_r;
      z6_r   <= z5_r;
      qd6_r  <= qd5_r;
    end
    if (en[6]) begin
      t7_r  <= p7[27:14];
      z7_r  <= z6_r;
      qd7_r <= qd6_r;
    end
    if (en[7]) begin
      y8_r  <= p8[28:14];
      qd8_r <= qd7_r;
    end
    if (en[8]) begin
      sine_r <= sine_nxt;
    end
  end

  assign sine = sine_r;

endmodule
`default_nettype wire

>>> design/chirp_and_dual_tone_waveform_generator.sv
// Path: an input slot, then the nine sine slots, then the output register.
// Throughput: one item per cycle while the output is not stalled; an 11-slot
// pipeline with per-slot valid collapses bubbles, so under an output stall input
// flows on until 11 items wait. Sine path: at most one multiplier per slot.
// Reset (rst_n low, synchronous): pipeline empty, generator idle, registers default.
`default_nettype none
module chirp_and_dual_tone_waveform_generator #(
  parameter int PREAMBLE_LENGTH  = 512,
  parameter int SYMBOL_LENGTH    = 48,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire          clk,
  input  wire          rst_n,
  cdtwg_in_if.sink     in_ch,
  cdtwg_out_if.source  out_ch,
  cdtwg_cfg_if.sink    cfg_ch
);
  import cdtwg_pkg::*;

  localparam int NP = SINE_STAGES + 2;
  localparam logic [CNT_W:0] HALF_LIM = (CNT_W + 1)'(PREAMBLE_LENGTH / 2);
  localparam logic [CNT_W:0] PRE_LIM  = (CNT_W + 1)'(PREAMBLE_LENGTH);
  localparam logic [CNT_W:0] SYM_LIM  = (CNT_W + 1)'(SYMBOL_LENGTH);

  // config
  logic [31:0] start_r, end_r, delta_r, tone_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= RST_CHIRP_START;
      end_r   <= RST_CHIRP_END;
      delta_r <= RST_CHIRP_DELTA;
      tone_r  <= RST_TONE_INC;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_CHIRP_START: start_r <= cfg_ch.data;
        CFG_CHIRP_END:   end_r   <= cfg_ch.data;
        CFG_CHIRP_DELTA: delta_r <= cfg_ch.data;
        CFG_TONE_INC:    tone_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic [NP-1:0] vld_r;
  logic [NP-1:0] rdy;
  logic [NP-1:0] en;
  logic          acc;

  always_comb begin
    rdy[NP-1] = !vld_r[NP-1] || out_ch.ready;
    for (int p = NP - 2; p >= 0; p--) begin
      rdy[p] = !vld_r[p] || rdy[p+1];
    end
  end

  assign acc         = in_ch.valid && rdy[0];
  assign in_ch.ready = rdy[0];

  always_comb begin
    en[0] = acc;
    for (int p = 1; p < NP; p++) begin
      en[p] = rdy[p] && vld_r[p-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_ch.valid;
      end
      for (int p = 1; p < NP; p++) begin
        if (rdy[p]) begin
          vld_r[p] <= vld_r[p-1];
        end
      end
    end
  end

  // generator state
  mode_t            mode_r, mode_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [31:0]      fw_r, fw_nxt;
  logic [31:0]      cph_r, cph_nxt;
  logic [31:0]      tph_r, tph_nxt;
  logic [SYM_W-1:0] sym_r, sym_nxt;
  logic [32:0]      avg_sum;
  logic [CNT_W:0]   lim;
  logic             produce;
  logic             is_pre;
  ctrl_t            ctrl_nxt;
  action_t          act;

  assign act     = action_t'(in_ch.action);
  assign cnt_inc = cnt_r + 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    fw_nxt   = fw_r;
    cph_nxt  = cph_r;
    tph_nxt  = tph_r;
    sym_nxt  = sym_r;
    produce  = 1'b0;
    avg_sum  = '0;
    unique case (act)
      ACT_PREAMBLE: begin
        mode_nxt = MODE_PRE;
        cnt_nxt  = '0;
        fw_nxt   = start_r;
        cph_nxt  = '0;
        produce  = 1'b1;
      end
      ACT_SYMBOL: begin
        mode_nxt = MODE_SYM;
        cnt_nxt  = '0;
        tph_nxt  = '0;
        sym_nxt  = in_ch.symbol;
        produce  = 1'b1;
      end
      ACT_NEXT: begin
        if (mode_r != MODE_IDLE) begin
          cnt_nxt = cnt_inc;
          produce = 1'b1;
          if (mode_r == MODE_PRE) begin
            if ({1'b0, cnt_inc} < HALF_LIM) begin
              fw_nxt = fw_r + delta_r;
            end else if ({1'b0, cnt_inc} == HALF_LIM) begin
              fw_nxt = end_r;
            end else begin
              fw_nxt = fw_r - delta_r;
            end
            avg_sum = {1'b0, fw_nxt} + {1'b0, fw_r};
            cph_nxt = cph_r + avg_sum[32:1];
          end else begin
            tph_nxt = tph_r + tone_r;
          end
        end
      end
      default: ;
    endcase

    is_pre = (mode_nxt == MODE_PRE);
    lim    = is_pre ? PRE_LIM : SYM_LIM;

    ctrl_nxt.is_sym = !is_pre;
    ctrl_nxt.neg_a  = !is_pre && sym_nxt[1];
    ctrl_nxt.neg_b  = !is_pre && sym_nxt[0];
    ctrl_nxt.active = produce;
    ctrl_nxt.last   = produce && (({1'b0, cnt_nxt} + 1'b1) >= lim);
    if (ctrl_nxt.last) begin
      mode_nxt = MODE_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      cnt_r  <= '0;
      fw_r   <= '0;
      cph_r  <= '0;
      tph_r  <= '0;
      sym_r  <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      fw_r   <= fw_nxt;
      cph_r  <= cph_nxt;
      tph_r  <= tph_nxt;
      sym_r  <= sym_nxt;
    end
  end

  // input slot and control side pipe
  logic [31:0] pha_r, phb_r;
  ctrl_t       ctrl_r [NP-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pha_r     <= is_pre ? cph_nxt : tph_nxt;
      phb_r     <= {tph_nxt[30:0], 1'b0};
      ctrl_r[0] <= ctrl_nxt;
    end
    for (int p = 1; p < NP - 1; p++) begin
      if (en[p]) begin
        ctrl_r[p] <= ctrl_r[p-1];
      end
    end
  end

  // sine units
  logic signed [SMP_W-1:0] sa, sb;

  cdtwg_sine #(.DEPTH(SINE_TABLE_DEPTH)) u_sine_a (
    .clk   (clk),
    .en    (en[NP-2:1]),
    .phase (pha_r),
    .sine  (sa)
  );

  cdtwg_sine #(.DEPTH(SINE_TABLE_DEPTH)) u_sine_b (
    .clk   (clk),
    .en    (en[NP-2:1]),
    .phase (phb_r),
    .sine  (sb)
  );

  // output register
  ctrl_t                   cf;
  logic signed [SMP_W-1:0] sa_s, sb_s, smp_nxt;
  logic signed [SMP_W-1:0] smp_r;
  logic                    last_r, act_r;

  assign cf   = ctrl_r[NP-2];
  assign sa_s = cf.neg_a ? -sa : sa;
  assign sb_s = cf.neg_b ? -sb : sb;

  always_comb begin
    if (!cf.active) begin
      smp_nxt = '0;
    end else if (cf.is_sym) begin
      smp_nxt = sa_s + sb_s;
    end else begin
      smp_nxt = sa;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NP-1]) begin
      smp_r  <= smp_nxt;
      last_r <= cf.last;
      act_r  <= cf.active;
    end
  end

  assign out_ch.valid  = vld_r[NP-1];
  assign out_ch.sample = smp_r;
  assign out_ch.last   = last_r;
  assign out_ch.active = act_r;

  a_acc_fills_slot: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> vld_r[0])
    else $error("accepted item did not enter the pipeline");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc && ctrl_nxt.last |=> mode_r == MODE_IDLE)
    else $error("generator not idle after final sample");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_PRE |-> ({1'b0, cnt_r} + 1'b1) < PRE_LIM)
    else $error("preamble count past its final sample");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.active |-> out_ch.sample == '0 && !out_ch.last)
    else $error("idle result carries a sample or last");

  a_sym_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_SYM |-> ({1'b0, cnt_r} + 1'b1) < SYM_LIM)
    else $error("symbol count past its final sample");

endmodule
`default_nettype wire
